[rtl/core/ksh_pkg.sv]
// Shared types, codes and helpers for the k-mer store with Hamming search.
// Used by the controller, the datapath, the top level and the port checker.
`default_nettype none

package ksh_pkg;

  // Sizing defaults and fixed field widths.
  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned MaxKmerBases  = 32;
  localparam int unsigned KmerW         = 64;
  localparam int unsigned LenW          = 6;
  localparam int unsigned StatusW       = 3;
  localparam logic [LenW-1:0] KmerLengthRst = 6'd3;

  // Command codes on the input tuser.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Register index decoded from the APB address.
  localparam logic REG_KMER_LENGTH = 1'b0;

  // Result status codes.
  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_FULL     = 3'd2,
    ST_MATCH    = 3'd3,
    ST_NOMATCH  = 3'd4
  } status_e;

  // What the datapath loads into the output register.
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_INSERTED,
    EMIT_PRESENT,
    EMIT_FULL,
    EMIT_PEND_MID,
    EMIT_PEND_LAST,
    EMIT_NOMATCH
  } emit_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic  load_item;
    logic  rd_en;
    logic  idx_inc;
    logic  take_pend;
    logic  wr_en;
    emit_e emit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_query;
    logic hit;
    logic pend_valid;
    logic out_free;
    logic last_entry;
    logic empty;
    logic full;
  } dp_stat_t;

  // Two-bit mask per base that takes part in a comparison.
  function automatic logic [KmerW-1:0] length_mask(input logic [LenW-1:0] len);
    logic [LenW-1:0]  act;
    logic [KmerW-1:0] m;
    act = (len > LenW'(MaxKmerBases)) ? LenW'(MaxKmerBases) : len;
    for (int b = 0; b < KmerW / 2; b++) begin
      m[2*b +: 2] = {2{(LenW'(b) < act)}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/core/ksh_ctrl.sv]
// Sequencer for the k-mer store: steps through the table one entry at a time.
// Depends on ksh_pkg for the command and status structs.
`default_nettype none

module ksh_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire ksh_pkg::dp_stat_t stat_i,
  output ksh_pkg::dp_cmd_t       cmd_o
);
  import ksh_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit = EMIT_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = stat_i.empty ? S_FIN : S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (!stat_i.is_query && stat_i.hit) begin
          // Insert of a k-mer that is already stored.
          if (stat_i.out_free) begin
            cmd_o.emit = EMIT_PRESENT;
            state_d = S_IDLE;
          end
        end else if (!(stat_i.hit && stat_i.pend_valid && !stat_i.out_free)) begin
          // A query hit replaces the held match, which goes out as non-last.
          if (stat_i.is_query && stat_i.hit) begin
            cmd_o.take_pend = 1'b1;
            if (stat_i.pend_valid) begin
              cmd_o.emit = EMIT_PEND_MID;
            end
          end
          if (stat_i.last_entry) begin
            state_d = S_FIN;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_FIN: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
          if (!stat_i.is_query) begin
            if (stat_i.full) begin
              cmd_o.emit = EMIT_FULL;
            end else begin
              cmd_o.wr_en = 1'b1;
              cmd_o.emit  = EMIT_INSERTED;
            end
          end else begin
            cmd_o.emit = stat_i.pend_valid ? EMIT_PEND_LAST : EMIT_NOMATCH;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/ksh_dp.sv]
// Datapath of the k-mer store: entry memory, fill count, base comparator,
// held match and output register. Depends on ksh_pkg.
`default_nettype none

module ksh_dp #(
  parameter int unsigned TABLE_DEPTH = ksh_pkg::TableDepthDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic [ksh_pkg::LenW-1:0]     kmer_length_i,
  input  wire logic                         cmd_i,
  input  wire logic [ksh_pkg::KmerW-1:0]    kmer_i,
  input  wire logic [ksh_pkg::LenW-1:0]     limit_i,
  input  wire ksh_pkg::dp_cmd_t             cmd_in_i,
  output ksh_pkg::dp_stat_t                 stat_o,
  input  wire logic                         out_ready_i,
  output logic                              out_valid_o,
  output logic [ksh_pkg::StatusW-1:0]       out_status_o,
  output logic [ksh_pkg::KmerW-1:0]         out_bases_o,
  output logic                              out_last_o
);
  import ksh_pkg::*;

  localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NumBases = KmerW / 2;

  // Item held for the length of one scan.
  logic             cmd_q;
  logic [KmerW-1:0] key_q;
  logic [KmerW-1:0] mask_q;
  logic [LenW-1:0]  limit_q;

  logic [IdxW-1:0]  idx_q;
  logic [CntW-1:0]  count_q;
  logic [KmerW-1:0] mem_q [TABLE_DEPTH];
  logic [KmerW-1:0] rd_data_q;

  logic             pend_valid_q;
  logic [KmerW-1:0] pend_bases_q;

  logic               out_valid_q;
  status_e            out_status_q;
  logic [KmerW-1:0]   out_bases_q;
  logic               out_last_q;
  logic               out_free;

  logic [KmerW-1:0]    diff_bits;
  logic [NumBases-1:0] diff_base;
  logic [LenW-1:0]     mm_cnt;
  logic                hit;

  // Item capture; the stored key keeps only the active bases.
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.load_item) begin
      cmd_q   <= cmd_i;
      key_q   <= kmer_i & length_mask(kmer_length_i);
      mask_q  <= length_mask(kmer_length_i);
      limit_q <= limit_i;
    end
  end

  // Scan index and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      count_q <= '0;
    end else begin
      if (cmd_in_i.load_item) begin
        idx_q <= '0;
      end else if (cmd_in_i.idx_inc) begin
        idx_q <= idx_q + IdxW'(1);
      end
      if (cmd_in_i.wr_en) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // Entry memory: one write and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.wr_en) begin
      mem_q[count_q[IdxW-1:0]] <= key_q;
    end
    if (cmd_in_i.rd_en) begin
      rd_data_q <= mem_q[idx_q];
    end
  end

  // Per-base difference and Hamming distance of the entry just read.
  always_comb begin
    diff_bits = (rd_data_q ^ key_q) & mask_q;
    for (int b = 0; b < NumBases; b++) begin
      diff_base[b] = diff_bits[2*b] | diff_bits[2*b+1];
    end
    mm_cnt = LenW'($countones(diff_base));
    hit    = (cmd_q == CMD_QUERY) ? (mm_cnt <= limit_q) : (diff_base == '0);
  end

  // Held match: it becomes last only once the scan ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_in_i.take_pend) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_in_i.load_item || cmd_in_i.emit == EMIT_PEND_LAST) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.take_pend) begin
      pend_bases_q <= rd_data_q;
    end
  end

  // Output register.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_in_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_in_i.emit)
      EMIT_INSERTED: begin
        out_status_q <= ST_INSERTED;
        out_bases_q  <= '0;
        out_last_q   <= 1'b1;
      end
      EMIT_PRESENT: begin
        out_status_q <= ST_PRESENT;
        out_bases_q  <= '0;
        out_last_q   <= 1'b1;
      end
      EMIT_FULL: begin
        out_status_q <= ST_FULL;
        out_bases_q  <= '0;
        out_last_q   <= 1'b1;
      end
      EMIT_PEND_MID: begin
        out_status_q <= ST_MATCH;
        out_bases_q  <= pend_bases_q;
        out_last_q   <= 1'b0;
      end
      EMIT_PEND_LAST: begin
        out_status_q <= ST_MATCH;
        out_bases_q  <= pend_bases_q;
        out_last_q   <= 1'b1;
      end
      EMIT_NOMATCH: begin
        out_status_q <= ST_NOMATCH;
        out_bases_q  <= '0;
        out_last_q   <= 1'b1;
      end
      default: begin
        out_status_q <= out_status_q;
      end
    endcase
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_bases_o  = out_bases_q;
  assign out_last_o   = out_last_q;

  // Status back to the controller.
  always_comb begin
    stat_o.is_query   = (cmd_q == CMD_QUERY);
    stat_o.hit        = hit;
    stat_o.pend_valid = pend_valid_q;
    stat_o.out_free   = out_free;
    stat_o.last_entry = ((CntW'(idx_q) + CntW'(1)) == count_q);
    stat_o.empty      = (count_q == '0);
    stat_o.full       = (count_q == CntW'(TABLE_DEPTH));
  end

endmodule

`default_nettype wire

[rtl/core/kmer_store_hamming_search_unit.sv]
// K-mer store with Hamming-distance search.
// Input stream: tuser = cmd (0 insert, 1 query); tdata = kmer_bases, then
// max_mismatches. Output stream: tuser = status, tdata = match_bases, tlast
// marks the final result of an item. kmer_length sits at APB address 0.
//
// An item is taken only while the unit is idle. Every item walks the stored
// entries in order, each entry read from memory and then compared, and it
// holds the unit until its final result is loaded into the output register;
// an insert that meets its k-mer stops at that entry.
// An insert answers once (inserted, already present or table full). A query
// sends each matching entry as soon as the next match or the end of the walk
// is known, so results trail by one match; it ends with tlast, or sends one
// no-match beat.
// Results leave through an output register; while the receiver stalls the
// walk pauses at the next result it must hand over. A new item may be taken
// while the last result still waits. Reset empties the table (fill count to
// zero) and sets kmer_length to 3; no clearing pass is needed.
// Depends on ksh_pkg, ksh_ctrl and ksh_dp.
`default_nettype none

module kmer_store_hamming_search_unit #(
  parameter int unsigned TABLE_DEPTH = ksh_pkg::TableDepthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input beats.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,  // [63:0] kmer_bases, [69:64] max_mismatches
  input  wire logic        s_axis_tuser,  // [0] cmd
  // Result beats.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,  // [63:0] match_bases
  output logic [2:0]       m_axis_tuser,  // [2:0] status
  output logic             m_axis_tlast,
  // Register port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import ksh_pkg::*;

  logic [LenW-1:0] kmer_length_q;
  logic            reg_sel;
  dp_cmd_t         dp_cmd;
  dp_stat_t        dp_stat;

  // Configuration register.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_KMER_LENGTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_length_q <= KmerLengthRst;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      kmer_length_q <= pwdata[LenW-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-LenW){1'b0}}, kmer_length_q} : 32'd0;

  ksh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (dp_stat),
    .cmd_o      (dp_cmd)
  );

  ksh_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .kmer_length_i (kmer_length_q),
    .cmd_i         (s_axis_tuser),
    .kmer_i        (s_axis_tdata[KmerW-1:0]),
    .limit_i       (s_axis_tdata[KmerW +: LenW]),
    .cmd_in_i      (dp_cmd),
    .stat_o        (dp_stat),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_status_o  (m_axis_tuser),
    .out_bases_o   (m_axis_tdata),
    .out_last_o    (m_axis_tlast)
  );

endmodule

`default_nettype wire

[rtl/core/ksh_checker.sv]
// Port-level checks for the k-mer store, bound to the top level.
// Depends on ksh_pkg for the status codes.
`default_nettype none

module ksh_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser,
  input wire logic        m_axis_tlast
);
  import ksh_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result beat changed");

  // One item at a time: the unit is busy right after taking one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in progress");

  // Insert answers and the no-match answer are single, last and carry no bases.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_INSERTED || m_axis_tuser == ST_PRESENT
      || m_axis_tuser == ST_FULL || m_axis_tuser == ST_NOMATCH)
    |-> m_axis_tlast && (m_axis_tdata == 64'd0))
    else $error("non-match result not last or has bases");

endmodule

bind kmer_store_hamming_search_unit ksh_checker u_ksh_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

[verif/ksh_result_checker.sv]
// Result checker for the k-mer store with Hamming search: watches the input,
// result and register channels, predicts every result beat and compares.
// Depends on ksh_pkg for the status codes, command codes and field widths.
module ksh_result_checker #(
  parameter int unsigned DEPTH = ksh_pkg::TableDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  input  logic [71:0]       s_axis_tdata,  // [63:0] kmer_bases, [69:64] max_mismatches
  input  logic              s_axis_tuser,  // [0] cmd
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  input  logic [63:0]       m_axis_tdata,  // [63:0] match_bases
  input  logic [2:0]        m_axis_tuser,  // [2:0] status
  input  logic              m_axis_tlast,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       fail_cnt_o,
  output int unsigned       pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ksh_pkg::*;

  localparam logic [2:0] LenAddr = {REG_KMER_LENGTH, 2'b00};

  typedef struct {
    status_e          status;
    logic [KmerW-1:0] bases;
    logic             is_last;
  } result_t;

  // Shadow copy of the table and the length register.
  logic [KmerW-1:0] tbl_bases [DEPTH];
  logic [DEPTH-1:0] tbl_valid;
  int unsigned      tbl_fill;
  logic [LenW-1:0]  cur_len;

  // Result beats predicted but not yet seen, oldest first.
  result_t          pending_beats [$];

  task automatic flag_mismatch(input string msg);
    fail_cnt_o++;
    // Keep the log readable if the design is badly broken.
    if (fail_cnt_o <= 100) $display("ksh_chk: %s (at %0t)", msg, $realtime);
  endtask

  // Append one predicted beat at the young end of the list.
  task automatic queue_beat(input result_t r);
    pending_beats.insert(pending_beats.size(), r);
  endtask

  // Two bits per base that take part in a comparison; lengths past the
  // largest k-mer are clamped.
  function automatic logic [KmerW-1:0] len_mask(input logic [LenW-1:0] len);
    logic [KmerW-1:0] m;
    int unsigned      act;
    act = (len > MaxKmerBases) ? MaxKmerBases : len;
    m = '0;
    for (int b = 0; b < KmerW / 2; b++) begin
      if (b < act) m[2*b +: 2] = 2'b11;
    end
    return m;
  endfunction

  // Count of bases that differ under the mask.
  function automatic int unsigned base_mismatch_count(input logic [KmerW-1:0] a,
                                                      input logic [KmerW-1:0] b,
                                                      input logic [KmerW-1:0] m);
    logic [KmerW-1:0] d;
    int unsigned      n;
    d = (a ^ b) & m;
    n = 0;
    for (int i = 0; i < KmerW / 2; i++) begin
      if (d[2*i +: 2] != 2'b00) n++;
    end
    return n;
  endfunction

  // Work out the result beats of one accepted item and update the table.
  task automatic apply_item(input logic cmd, input logic [KmerW-1:0] kmer,
                            input logic [LenW-1:0] limit);
    logic [KmerW-1:0] m;
    logic [KmerW-1:0] key;
    bit               seen;
    bit               have_held;
    result_t          held;
    m = len_mask(cur_len);
    key = kmer & m;
    if (cmd == CMD_INSERT) begin
      seen = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && ((tbl_bases[i] & m) == key)) seen = 1'b1;
      end
      if (seen) begin
        queue_beat('{ST_PRESENT, '0, 1'b1});
      end else if (tbl_fill >= DEPTH) begin
        queue_beat('{ST_FULL, '0, 1'b1});
      end else begin
        tbl_bases[tbl_fill] = key;
        tbl_valid[tbl_fill] = 1'b1;
        tbl_fill++;
        queue_beat('{ST_INSERTED, '0, 1'b1});
      end
    end else begin
      // Hold each match back one step so the final one can carry tlast.
      have_held = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        if (tbl_valid[i] && base_mismatch_count(tbl_bases[i], key, m) <= int'(limit)) begin
          if (have_held) queue_beat(held);
          held = '{ST_MATCH, tbl_bases[i], 1'b0};
          have_held = 1'b1;
        end
      end
      if (have_held) begin
        held.is_last = 1'b1;
        queue_beat(held);
      end else begin
        queue_beat('{ST_NOMATCH, '0, 1'b1});
      end
    end
  endtask

  // Compare one result beat with the oldest prediction, field by field.
  task automatic check_beat();
    result_t want;
    if (pending_beats.size() == 0) begin
      flag_mismatch($sformatf("result beat with nothing outstanding: status %0d bases %h",
                              m_axis_tuser, m_axis_tdata));
    end else begin
      want = pending_beats.pop_front();
      if (m_axis_tuser !== want.status)
        flag_mismatch($sformatf("status %0d, want %0d", m_axis_tuser, want.status));
      if (m_axis_tdata !== want.bases)
        flag_mismatch($sformatf("match_bases %h, want %h", m_axis_tdata, want.bases));
      if (m_axis_tlast !== want.is_last)
        flag_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want.is_last));
    end
  endtask

  // Results are checked before the new item is predicted: a beat leaving at
  // the same edge always belongs to an older item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_valid = '0;
      tbl_fill = 0;
      cur_len = KmerLengthRst;
      pending_beats.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (psel && penable && pwrite && pready && paddr == LenAddr)
        cur_len = pwdata[LenW-1:0];
      if (s_axis_tvalid && s_axis_tready)
        apply_item(s_axis_tuser, s_axis_tdata[KmerW-1:0], s_axis_tdata[KmerW +: LenW]);
    end
    pend_cnt_o = pending_beats.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for the k-mer store with Hamming search: clock, reset,
// directed and random input beats, register writes and the verdict.
// Depends on ksh_pkg, kmer_store_hamming_search_unit and ksh_result_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ksh_pkg::*;

  localparam logic [2:0] LenAddr = {REG_KMER_LENGTH, 2'b00};

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;  // [63:0] kmer_bases, [69:64] max_mismatches
  logic        s_axis_tuser = 1'b0;  // [0] cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;  // [63:0] match_bases
  logic [2:0]  m_axis_tuser;  // [2:0] status
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_cnt;
  int unsigned pend_cnt;
  bit          calm = 1'b0;  // no idling on either side while set
  logic [63:0] sent_kmers [$];

  // Lengths used by the random phases, the extremes among them.
  int unsigned phase_len [11] = '{2, 4, 1, 7, 32, 16, 63, 0, 5, 31, 3};

  kmer_store_hamming_search_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  ksh_result_checker u_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pready        (pready),
    .fail_cnt_o    (fail_cnt),
    .pend_cnt_o    (pend_cnt)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Receiver stalls at random except in the calm stretch.
  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 26);
  end

  // Present one input beat after a random gap and hold it until taken.
  // Called and returns at a falling edge.
  task automatic send_item(input logic cmd, input logic [63:0] kmer, input logic [5:0] mm);
    while (!calm && $urandom_range(0, 99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= cmd;
    s_axis_tdata <= {2'b00, mm, kmer};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Stop sending, wait for every outstanding result, then let the unit settle.
  task automatic quiesce(input int unsigned extra);
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pend_cnt != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle until pready.
  task automatic write_len(input logic [5:0] len);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LenAddr;
    pwdata <= {26'd0, len};
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // A k-mer a few bases away from src within the active length.
  function automatic logic [63:0] near_kmer(input logic [63:0] src, input int unsigned len,
                                            input int unsigned flips);
    logic [63:0] v;
    int unsigned act;
    int unsigned b;
    v = src;
    act = (len > 32) ? 32 : len;
    if (act != 0) begin
      for (int j = 0; j < flips; j++) begin
        b = $urandom_range(0, act - 1);
        v[2*b +: 2] = v[2*b +: 2] ^ 2'($urandom_range(1, 3));
      end
    end
    return v;
  endfunction

  // Mostly inserts and near-miss queries built from k-mers already sent,
  // the rest random queries with any limit.
  task automatic random_item(input int unsigned len);
    int unsigned r;
    logic [63:0] rnd;
    logic [63:0] k;
    r = $urandom_range(0, 99);
    rnd = {$urandom, $urandom};
    if (sent_kmers.size() == 0) k = rnd;
    else k = near_kmer(sent_kmers[$urandom_range(0, sent_kmers.size() - 1)], len,
                       $urandom_range(0, 3));
    if (r < 40) begin
      if ($urandom_range(0, 1) != 0) k = rnd;
      sent_kmers.insert(sent_kmers.size(), k);
      send_item(CMD_INSERT, k, 6'($urandom_range(0, 32)));
    end else if (r < 82) begin
      send_item(CMD_QUERY, k, 6'($urandom_range(0, 4)));
    end else if (r < 94) begin
      send_item(CMD_QUERY, rnd, 6'($urandom_range(0, 32)));
    end else begin
      send_item(CMD_QUERY, rnd, 6'd0);
    end
  endtask

  initial begin
    logic [63:0] k;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Length 3 after reset: empty table, bits above the length ignored.
    send_item(CMD_QUERY, 64'h0, 6'd0);
    send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
    send_item(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AA3F, 6'd32);
    send_item(CMD_INSERT, 64'h0, 6'd0);
    send_item(CMD_INSERT, 64'h1B, 6'd0);
    send_item(CMD_QUERY, 64'h3F, 6'd0);
    send_item(CMD_QUERY, 64'h3F, 6'd32);
    send_item(CMD_QUERY, 64'h3E, 6'd1);
    send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFC0, 6'd0);
    send_item(CMD_QUERY, 64'h15, 6'd3);
    send_item(CMD_QUERY, 64'h15, 6'd0);

    // Length zero: every stored entry counts as equal.
    quiesce(8);
    write_len(6'd0);
    send_item(CMD_INSERT, 64'h0123_4567_89AB_CDEF, 6'd0);
    send_item(CMD_QUERY, 64'hFEDC_BA98_7654_3210, 6'd0);

    // Length beyond the largest k-mer is clamped to 32 bases.
    quiesce(8);
    write_len(6'd63);
    send_item(CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
    send_item(CMD_INSERT, 64'h8000_0000_0000_0000, 6'd0);
    send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
    send_item(CMD_QUERY, 64'h7FFF_FFFF_FFFF_FFFF, 6'd1);
    send_item(CMD_QUERY, 64'h0, 6'd32);

    // One base: older entries are compared on their low base only.
    quiesce(8);
    write_len(6'd1);
    send_item(CMD_QUERY, 64'h3, 6'd0);
    send_item(CMD_INSERT, 64'h2, 6'd0);
    send_item(CMD_INSERT, 64'h1, 6'd0);
    send_item(CMD_INSERT, 64'h5, 6'd0);
    send_item(CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFD, 6'd1);

    // Random phases, each after the unit has drained.
    foreach (phase_len[p]) begin
      quiesce(8);
      write_len(6'(phase_len[p]));
      calm = (phase_len[p] == 16);
      // Full length: fill the table past its depth to reach table full.
      if (phase_len[p] == 32) begin
        repeat (70) begin
          k = {$urandom, $urandom};
          sent_kmers.insert(sent_kmers.size(), k);
          send_item(CMD_INSERT, k, 6'($urandom_range(0, 32)));
        end
      end
      repeat (17) random_item(phase_len[p]);
    end
    calm = 1'b0;

    quiesce(140);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("[kmer_store_hamming_search_unit] OK");
    end else begin
      $display("[kmer_store_hamming_search_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[kmer_store_hamming_search_unit] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/core/ksh_pkg.sv
rtl/core/ksh_ctrl.sv
rtl/core/ksh_dp.sv
rtl/core/kmer_store_hamming_search_unit.sv
rtl/core/ksh_checker.sv
verif/ksh_result_checker.sv
verif/tb.sv
